// File: hw/rtl/held_lock_tracker_core_defines.svh
// Assertion macros for the lock tracker checker file.
`ifndef HELD_LOCK_TRACKER_CORE_DEFINES_SVH
`define HELD_LOCK_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HLT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("held lock tracker check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define HLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("held lock tracker check failed");

`endif

// File: hw/rtl/hlt_pkg.sv
// Types and codes for the held lock tracker.
package hlt_pkg;

    localparam int DEPTH_W = 7;

    localparam logic [1:0] FUNC_CHECK = 2'd0;
    localparam logic [1:0] FUNC_ENTER = 2'd1;
    localparam logic [1:0] FUNC_EXIT  = 2'd2;

    localparam logic [1:0] LATCH_UNSEEN = 2'd0;
    localparam logic [1:0] LATCH_UNSAFE = 2'd1;
    localparam logic [1:0] LATCH_SAFE   = 2'd2;
    localparam logic [1:0] LATCH_BAD    = 2'd3;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_RECURSIVE    = 3'd1;
    localparam logic [2:0] ST_MISMATCH     = 3'd2;
    localparam logic [2:0] ST_OVERFLOW     = 3'd3;
    localparam logic [2:0] ST_NOT_RECORDED = 3'd4;

    localparam logic REG_DEPTH_LIMIT = 1'b0;
    localparam logic REG_CHECKS      = 1'b1;

    localparam logic [DEPTH_W-1:0] LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic capture;
        logic push;
        logic shift;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

// File: hw/rtl/held_lock_tracker_core.sv
// Held lock tracker top level: control, result registers and the row of stack cells.
//
// Usage:
//   Pulse start with func, lock_tag, try_only, irq_disabled and lock_latch while
//   busy is low; the item is taken at that edge. Each item yields one result:
//   done is high for exactly one cycle with status, latch_out and depth.
//   Busy is high only in the cycle after acceptance, and done is registered
//   from busy. A new item may be started in the cycle where done is high; no
//   new item is taken while busy is high.
//   Each cell registers the compare of its tag with the key when the item is
//   accepted; while busy, the row pushes or shifts and the count updates,
//   with a single carry-chain search finding the newest match.
//   Config: cfg_we writes cfg_wdata into the register cfg_index (0 depth limit,
//   1 checks enable), to be done only while the block is idle.
//   Reset: the stack count and overflow flag clear, depth limit becomes 64 and
//   checks are off; no clearing pass is needed. Results cannot be stalled.
module held_lock_tracker_core #(
    parameter int MAX_DEPTH = 64,
    parameter int TAG_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   func,
    input  logic [TAG_WIDTH-1:0]         lock_tag,
    input  logic                         try_only,
    input  logic                         irq_disabled,
    input  logic [1:0]                   lock_latch,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [1:0]                   latch_out,
    output logic [hlt_pkg::DEPTH_W-1:0]  depth,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [hlt_pkg::DEPTH_W-1:0]  cfg_wdata
);
    import hlt_pkg::*;

    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

    state_t state_reg, state_next;

    logic [1:0]           op_func_reg;
    logic [TAG_WIDTH-1:0] op_tag_reg;
    logic                 op_try_reg;
    logic                 op_irq_reg;
    logic [1:0]           op_latch_reg;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [DEPTH_W-1:0]   limit_reg;
    logic                 checks_reg;

    logic                 done_reg;
    logic [2:0]           status_reg, status_next;
    logic [1:0]           latch_out_reg, latch_out_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;

    logic                 accept;
    logic                 exec;
    logic                 enter_push;
    logic                 exit_hit;
    logic [1:0]           latch_in;
    logic [CMP_W-1:0]     lim_ext, eff_limit, cnt_ext;
    logic                 room;

    logic [MAX_DEPTH-1:0] hits, hits_rev, from_top, newest_mask;
    logic [TAG_WIDTH-1:0] cell_tag [MAX_DEPTH];

    assign accept = start && (state_reg == S_IDLE);
    assign exec   = (state_reg == S_EXEC);
    assign busy   = exec;

    // Newest match: in reversed order, x | -x sets every bit from the lowest hit up.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_DEPTH; gi++)
        begin : g_rev
            assign hits_rev[gi] = hits[MAX_DEPTH-1-gi];
            assign newest_mask[gi] = from_top[MAX_DEPTH-1-gi];
        end
    endgenerate
    assign from_top = hits_rev | (~hits_rev + {{(MAX_DEPTH-1){1'b0}}, 1'b1});

    generate
        for (gi = 0; gi < MAX_DEPTH; gi++)
        begin : g_cell
            cell_ctl_t ctl;
            logic [TAG_WIDTH-1:0] upper;
            logic shift_here;

            if (gi == MAX_DEPTH - 1)
            begin : g_top
                assign upper = cell_tag[gi];
                assign shift_here = 1'b1;
            end
            else
            begin : g_mid
                assign upper = cell_tag[gi+1];
                // shift every slot at or above the newest match
                assign shift_here = !newest_mask[gi+1];
            end

            assign ctl.capture = accept;
            assign ctl.push    = enter_push && (count_reg == CNT_W'(gi));
            assign ctl.shift   = exit_hit && shift_here;

            hlt_cell #(
                .TAG_WIDTH (TAG_WIDTH)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .occupied  (CNT_W'(gi) < count_reg),
                .key       (lock_tag),
                .push_tag  (op_tag_reg),
                .upper_tag (upper),
                .tag       (cell_tag[gi]),
                .hit       (hits[gi])
            );
        end
    endgenerate

    assign lim_ext   = CMP_W'(limit_reg);
    assign eff_limit = (lim_ext > CMP_W'(MAX_DEPTH)) ? CMP_W'(MAX_DEPTH) : lim_ext;
    assign room      = CMP_W'(count_reg) < eff_limit;
    assign latch_in  = (op_latch_reg == LATCH_BAD) ? LATCH_UNSEEN : op_latch_reg;

    always_comb
    begin
        status_next    = ST_OK;
        latch_out_next = LATCH_UNSEEN;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        enter_push     = 1'b0;
        exit_hit       = 1'b0;
        case (op_func_reg)
            FUNC_CHECK:
            begin
                latch_out_next = latch_in;
                if (checks_reg && !(op_try_reg && op_irq_reg))
                begin
                    if (latch_in == LATCH_UNSEEN)
                    begin
                        latch_out_next = op_irq_reg ? LATCH_SAFE : LATCH_UNSAFE;
                        if (!op_try_reg && (|hits))
                        begin
                            status_next = ST_RECURSIVE;
                        end
                    end
                    else if ((latch_in == LATCH_SAFE) != op_irq_reg)
                    begin
                        status_next = ST_MISMATCH;
                    end
                    else if (!op_try_reg && (|hits))
                    begin
                        status_next = ST_RECURSIVE;
                    end
                end
            end
            FUNC_ENTER:
            begin
                if (limit_reg != '0)
                begin
                    if (room)
                    begin
                        enter_push = exec;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (!ovf_reg)
                    begin
                        ovf_next    = 1'b1;
                        status_next = ST_OVERFLOW;
                    end
                end
            end
            FUNC_EXIT:
            begin
                if (limit_reg != '0)
                begin
                    if (|hits)
                    begin
                        exit_hit   = exec;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else if (!ovf_reg)
                    begin
                        status_next = ST_NOT_RECORDED;
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign cnt_ext    = CMP_W'(count_next);
    assign depth_next = cnt_ext[DEPTH_W-1:0];

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            limit_reg  <= LIMIT_RESET;
            checks_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (exec)
            begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEPTH_LIMIT: limit_reg  <= cfg_wdata;
                    REG_CHECKS:      checks_reg <= cfg_wdata[0];
                    default:         checks_reg <= checks_reg;
                endcase
            end
        end
    end

    // hold the item fields for the update cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_func_reg  <= func;
            op_tag_reg   <= lock_tag;
            op_try_reg   <= try_only;
            op_irq_reg   <= irq_disabled;
            op_latch_reg <= lock_latch;
        end
        if (exec)
        begin
            status_reg    <= status_next;
            latch_out_reg <= latch_out_next;
            depth_reg     <= depth_next;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign latch_out = latch_out_reg;
    assign depth     = depth_reg;

endmodule

// File: hw/rtl/hlt_cell.sv
// One stack slot: holds a tag, compares it against the key, shifts down from above.
module hlt_cell #(
    parameter int TAG_WIDTH = 32
) (
    input  logic                  clk,
    input  hlt_pkg::cell_ctl_t    ctl,
    input  logic                  occupied,
    input  logic [TAG_WIDTH-1:0]  key,
    input  logic [TAG_WIDTH-1:0]  push_tag,
    input  logic [TAG_WIDTH-1:0]  upper_tag,
    output logic [TAG_WIDTH-1:0]  tag,
    output logic                  hit
);
    import hlt_pkg::*;

    logic [TAG_WIDTH-1:0] tag_reg;
    logic                 hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            tag_reg <= push_tag;
        end
        else if (ctl.shift)
        begin
            tag_reg <= upper_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            hit_reg <= occupied && (tag_reg == key);
        end
    end

    assign tag = tag_reg;
    assign hit = hit_reg;

endmodule

// File: hw/rtl/hlt_checker.sv
// Port-level checker for the held lock tracker, bound to the top level.
`include "held_lock_tracker_core_defines.svh"

module hlt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [1:0]  latch_out
);
    import hlt_pkg::*;

    logic latch_ok;

    // an overflow comes only from enter, which never returns a latch
    assign latch_ok = (latch_out != LATCH_BAD) &&
                      ((latch_out == LATCH_UNSEEN) || (status != ST_OVERFLOW));

    `HLT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
    `HLT_ASSERT_NEXT(a_busy_done, busy, done && !busy)
    `HLT_ASSERT_NOW(a_done_after_busy, done, $past(busy))
    `HLT_ASSERT_NOW(a_status_code, done, status <= ST_NOT_RECORDED)
    `HLT_ASSERT_NOW(a_latch_code, done, latch_ok)

endmodule

bind held_lock_tracker_core hlt_checker u_hlt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .latch_out (latch_out)
);
